[hdl/fbpa_pkg.sv]
package fbpa_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS = 128;
  localparam int SEG_BITS   = 16;   // busy bits held by one cell
  localparam int SEG_W      = 4;    // log2(SEG_BITS)
  localparam int NUM_CELLS  = (MAX_BLOCKS + SEG_BITS - 1) / SEG_BITS;
  localparam int CELL_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int IDX_W      = CELL_W + SEG_W;
  localparam int CNT_W      = IDX_W + 1;

  // Field and register widths
  localparam int BB_W      = 13;
  localparam int BC_W      = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int IN_OFF_W  = 21;
  localparam int POS_W     = IN_OFF_W - 1;
  localparam int OUT_OFF_W = 19;
  localparam int TALLY_W   = 20;
  localparam int BSIZE_W   = 13;

  localparam int BB_MAX = 4096;
  localparam int ALIGN  = 8;

  localparam logic [BB_W-1:0] BB_RESET = 13'd32;
  localparam logic [BC_W-1:0] BC_RESET = 8'd100;

  // Derived internal widths
  localparam int CLAMP_W = (BC_W > CNT_W) ? BC_W : CNT_W;
  localparam int PROD_W  = BSIZE_W + IDX_W;
  localparam int DIV_W   = (PROD_W > POS_W) ? PROD_W : POS_W;
  localparam int POOL_W  = BSIZE_W + CNT_W;
  localparam int PCMP_W  = (POOL_W > POS_W) ? POOL_W : POS_W;
  localparam int STEP_W  = $clog2(IDX_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_BYTES = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Token passed down the cell chain
  typedef struct packed {
    logic              active;
    op_t               op;
    logic              found;
    logic [IDX_W-1:0]  idx;
  } tok_t;

  // Clamp to 1..4096 and round up to a multiple of ALIGN
  function automatic logic [BSIZE_W-1:0] eff_bsize(input logic [BB_W-1:0] bb);
    logic [BSIZE_W-1:0] b;
    b = bb;
    if (b == '0) b = BSIZE_W'(1);
    if (b > BSIZE_W'(BB_MAX)) b = BSIZE_W'(BB_MAX);
    b = b + BSIZE_W'(ALIGN - 1);
    b = b & ~BSIZE_W'(ALIGN - 1);
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] eff_count(input logic [BC_W-1:0] bc);
    logic [CLAMP_W-1:0] c;
    c = CLAMP_W'(bc);
    if (c > CLAMP_W'(MAX_BLOCKS)) c = CLAMP_W'(MAX_BLOCKS);
    return CNT_W'(c);
  endfunction

endpackage

[hdl/fixed_block_pool_allocator_top.sv]
// Fixed-size block pool allocator, busy bitmap held in a chain of cells.
// Input channel (in_valid / in_stall): one transaction is an alloc
// (in_opcode 0) or a free (in_opcode 1) with a signed byte offset.
// Result channel (out_valid / out_stall): exactly one transaction per
// request carrying ok, the allocated block's byte offset and the byte tally.
// Config port: cfg_we with cfg_index 0 = block bytes, 1 = block count.
// Write it only while no request is in flight.
// An alloc walks the token through the 8-cell chain. A free first runs the
// bit-per-cycle divider that maps the offset to a block index (a load plus
// 7 steps), then walks the chain, or skips the walk when the offset is
// negative or outside the pool. The block returns to idle as the result is
// loaded and takes the next request from the cycle after.
// Reset (synchronous, rst_n low) frees every block, zeroes the tally and
// loads block bytes 32, block count 100.
// A stalled result holds in the output register; the block still takes one
// more request and finishes it, then waits until the output slot frees.
module fixed_block_pool_allocator_top import fbpa_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_opcode,
  input  logic signed [IN_OFF_W-1:0] in_byte_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_ok,
  output logic [OUT_OFF_W-1:0]       out_block_offset,
  output logic [TALLY_W-1:0]         out_bytes_in_use,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a request
    S_DIV  = 4'b0010,  // free: offset -> block index
    S_SCAN = 4'b0100,  // token walking the cell chain
    S_DONE = 4'b1000   // result ready, waiting for output slot
  } state_t;

  state_t              state_r, state_nxt;
  logic [BB_W-1:0]     bb_r, bb_nxt;
  logic [BC_W-1:0]     bc_r, bc_nxt;
  op_t                 op_r, op_nxt;
  logic [POS_W-1:0]    raw_r, raw_nxt;
  logic                neg_r, neg_nxt;
  logic [POOL_W-1:0]   pool_r, pool_nxt;
  tok_t                inj_r, inj_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [TALLY_W-1:0]  tally_r, tally_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [OUT_OFF_W-1:0] out_offs_r, out_offs_nxt;

  logic [BSIZE_W-1:0]  bsize;
  logic [CNT_W-1:0]    count;
  logic                in_acc;
  logic                out_free;
  logic [POOL_W-1:0]   pool_calc;
  logic [PROD_W-1:0]   prod;
  logic [TALLY_W:0]    tally_add;
  logic                div_start;
  logic                div_done;
  logic [IDX_W-1:0]    div_quot;
  tok_t                chain_w [0:NUM_CELLS];

  assign bsize = eff_bsize(bb_r);
  assign count = eff_count(bc_r);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign pool_calc = POOL_W'(bsize) * POOL_W'(count);
  assign prod      = PROD_W'(res_idx_r) * PROD_W'(bsize);
  assign tally_add = {1'b0, tally_r} + (TALLY_W + 1)'(bsize);

  // offset / block size for free requests
  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIV_W'(in_byte_offset[POS_W-1:0])),
    .divisor  (bsize),
    .done     (div_done),
    .quot     (div_quot)
  );

  // busy bitmap: each cell owns SEG_BITS blocks, token moves one cell/cycle
  assign chain_w[0] = inj_r;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    fbpa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (CELL_W'(g)),
      .count    (count),
      .tok_i    (chain_w[g]),
      .tok_o    (chain_w[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    bb_nxt        = bb_r;
    bc_nxt        = bc_r;
    op_nxt        = op_r;
    raw_nxt       = raw_r;
    neg_nxt       = neg_r;
    pool_nxt      = pool_r;
    inj_nxt       = inj_r;
    inj_nxt.active = 1'b0;       // injection lasts one cycle
    res_ok_nxt    = res_ok_r;
    res_idx_nxt   = res_idx_r;
    tally_nxt     = tally_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_offs_nxt  = out_offs_r;
    div_start     = 1'b0;

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCK_BYTES: bb_nxt = cfg_wdata[BB_W-1:0];
        REG_BLOCK_COUNT: bc_nxt = cfg_wdata[BC_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = op_t'(in_opcode);
          raw_nxt  = in_byte_offset[POS_W-1:0];
          neg_nxt  = in_byte_offset[IN_OFF_W-1];
          pool_nxt = pool_calc;
          if (op_t'(in_opcode) == OP_ALLOC) begin
            inj_nxt.active = 1'b1;
            inj_nxt.op     = OP_ALLOC;
            inj_nxt.found  = 1'b0;
            inj_nxt.idx    = '0;
            state_nxt      = S_SCAN;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          // in-pool check also guarantees index < count
          if (!neg_r && (PCMP_W'(raw_r) < PCMP_W'(pool_r))) begin
            inj_nxt.active = 1'b1;
            inj_nxt.op     = OP_FREE;
            inj_nxt.found  = 1'b0;
            inj_nxt.idx    = div_quot;
            state_nxt      = S_SCAN;
          end else begin
            res_ok_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (chain_w[NUM_CELLS].active) begin
          res_ok_nxt  = chain_w[NUM_CELLS].found;
          res_idx_nxt = chain_w[NUM_CELLS].idx;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_offs_nxt  = (op_r == OP_ALLOC && res_ok_r) ? OUT_OFF_W'(prod) : '0;
          if (res_ok_r) begin
            if (op_r == OP_ALLOC) begin
              tally_nxt = tally_add[TALLY_W] ? '1 : tally_add[TALLY_W-1:0];
            end else begin
              tally_nxt = (tally_r < TALLY_W'(bsize)) ? '0 : tally_r - TALLY_W'(bsize);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bb_r        <= BB_RESET;
      bc_r        <= BC_RESET;
      inj_r       <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bb_r        <= bb_nxt;
      bc_r        <= bc_nxt;
      inj_r       <= inj_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    raw_r      <= raw_nxt;
    neg_r      <= neg_nxt;
    pool_r     <= pool_nxt;
    res_ok_r   <= res_ok_nxt;
    res_idx_r  <= res_idx_nxt;
    out_ok_r   <= out_ok_nxt;
    out_offs_r <= out_offs_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_block_offset = out_offs_r;
  assign out_bytes_in_use = tally_r;

endmodule

[hdl/fbpa_cell.sv]
module fbpa_cell import fbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CELL_W-1:0] cell_idx,
  input  logic [CNT_W-1:0]  count,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [SEG_BITS-1:0] busy_r, busy_nxt;
  tok_t                tok_r, tok_nxt;

  logic [IDX_W-1:0]    base;
  logic [SEG_BITS-1:0] in_range;
  logic [SEG_BITS-1:0] cand;
  logic [SEG_BITS-1:0] pick;
  logic [SEG_W-1:0]    pick_enc;
  logic [SEG_W-1:0]    fsel;
  logic                hit_seg;

  assign base    = {cell_idx, {SEG_W{1'b0}}};
  assign fsel    = tok_i.idx[SEG_W-1:0];
  assign hit_seg = (tok_i.idx[IDX_W-1:SEG_W] == cell_idx);

  // only blocks below the active count may be handed out
  always_comb begin
    for (int j = 0; j < SEG_BITS; j++) begin
      in_range[j] = ({1'b0, base | IDX_W'(j)} < count);
    end
  end

  assign cand = ~busy_r & in_range;
  assign pick = cand & (~cand + SEG_BITS'(1));  // lowest free bit, one-hot

  always_comb begin
    pick_enc = '0;
    for (int j = 0; j < SEG_BITS; j++) begin
      if (pick[j]) pick_enc = pick_enc | SEG_W'(j);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    tok_nxt  = tok_i;
    if (tok_i.active && !tok_i.found) begin
      if (tok_i.op == OP_ALLOC) begin
        if (|cand) begin
          busy_nxt      = busy_r | pick;
          tok_nxt.found = 1'b1;
          tok_nxt.idx   = base | IDX_W'(pick_enc);
        end
      end else if (hit_seg && busy_r[fsel]) begin
        busy_nxt[fsel] = 1'b0;
        tok_nxt.found  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      tok_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

[hdl/fbpa_div.sv]
module fbpa_div import fbpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [BSIZE_W-1:0] divisor,
  output logic               done,
  output logic [IDX_W-1:0]   quot
);

  // restoring division, one quotient bit per cycle, MSB first
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dsh_r, dsh_nxt;
  logic [IDX_W-1:0]  q_r, q_nxt;
  logic              ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_W'(IDX_W);
      rem_nxt  = dividend;
      dsh_nxt  = DIV_W'(divisor) << (IDX_W - 1);
      q_nxt    = '0;
    end else if (run_r) begin
      if (ge) rem_nxt = rem_r - dsh_r;
      dsh_nxt  = dsh_r >> 1;
      q_nxt    = (q_r << 1) | IDX_W'(ge);
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[hdl/fbpa_chk.sv]
module fbpa_chk import fbpa_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_ok,
  input logic [OUT_OFF_W-1:0]       out_block_offset,
  input logic [TALLY_W-1:0]         out_bytes_in_use
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) &&
      $stable(out_block_offset) && $stable(out_bytes_in_use))
    else $error("result changed while stalled");

  // failed transactions carry a zero offset
  a_zero_offs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_block_offset == '0)
    else $error("nonzero offset on failed transaction");

  // reset empties the pool and the output slot
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && out_bytes_in_use == '0)
    else $error("reset did not clear state");

  // one request at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // the tally moves only when a new result is loaded
  a_tally_move: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(out_bytes_in_use) |->
      out_valid && !$past(out_valid && out_stall))
    else $error("tally changed without a new result");

endmodule

bind fixed_block_pool_allocator_top fbpa_chk u_fbpa_chk (.*);

[verif/fixed_block_pool_allocator_top_test.sv]
`timescale 1ns / 100ps

module fixed_block_pool_allocator_top_test;
  import fbpa_pkg::*;

  // Run limits: cycles without any transaction before giving up, length of the
  // forced output hold, random phases and requests per phase.
  localparam int STUCK_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 60;
  localparam int NUM_PHASES   = 11;
  localparam int PHASE_ITEMS  = 48;
  localparam int TALLY_LIMIT  = (1 << TALLY_W) - 1;
  localparam int OFFSET_SPAN  = 1 << (IN_OFF_W - 1);

  // One reply as the block should present it.
  typedef struct {
    logic                 ok;
    logic [OUT_OFF_W-1:0] blk_off;
    logic [TALLY_W-1:0]   bytes;
  } alloc_reply_t;

  // Pool model plus reply queue. take_request() advances the model on every
  // accepted request and queues the reply it predicts; check_reply() pops the
  // oldest prediction and compares it with what came out.
  class alloc_scoreboard;
    bit                 busy[MAX_BLOCKS];
    logic [TALLY_W-1:0] tally;
    logic [BB_W-1:0]    blk_bytes;
    logic [BC_W-1:0]    blk_count;
    alloc_reply_t       pending_replies[$];
    int errors, n_checked, n_requests, n_settings;
    int n_granted, n_refused, n_freed, n_ignored;

    function new();
      foreach (busy[i]) busy[i] = 1'b0;
      tally = '0;
      blk_bytes = BB_RESET;
      blk_count = BC_RESET;
    endfunction

    // Requested size clamped to 1..4096, then rounded up to a multiple of 8 bytes.
    function int unsigned blk_size();
      int unsigned b;
      b = 32'(blk_bytes);
      if (b < 1) b = 1;
      if (b > BB_MAX) b = BB_MAX;
      return (b + ALIGN - 1) & ~(ALIGN - 1);
    endfunction

    function int unsigned pool_blocks();
      return (blk_count > MAX_BLOCKS) ? MAX_BLOCKS : 32'(blk_count);
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
      if (r == REG_BLOCK_BYTES) blk_bytes = v[BB_W-1:0];
      else blk_count = v[BC_W-1:0];
      n_settings++;
    endfunction

    // Random busy block within the pool, -1 if none.
    function int pick_busy();
      int unsigned cnt, start, idx;
      cnt = pool_blocks();
      if (cnt == 0) return -1;
      start = $urandom_range(0, cnt - 1);
      for (int k = 0; k < cnt; k++) begin
        idx = (start + k) % cnt;
        if (busy[idx]) return idx;
      end
      return -1;
    endfunction

    function void take_request(op_t op, logic [IN_OFF_W-1:0] off);
      alloc_reply_t rep;
      int unsigned bs, cnt, pos, idx;
      bs = blk_size();
      cnt = pool_blocks();
      rep.ok = 1'b0;
      rep.blk_off = '0;
      n_requests++;
      if (op == OP_ALLOC) begin
        for (int i = 0; i < cnt; i++) begin
          if (!busy[i]) begin
            busy[i] = 1'b1;
            if (tally > TALLY_LIMIT - bs) tally = TALLY_LIMIT;
            else tally = TALLY_W'(tally + bs);
            rep.blk_off = OUT_OFF_W'(i * bs);
            rep.ok = 1'b1;
            break;
          end
        end
        if (rep.ok) n_granted++;
        else n_refused++;
      end else begin
        // Sign bit set means a negative offset, never in the pool.
        if (!off[IN_OFF_W-1]) begin
          pos = 32'(off[IN_OFF_W-2:0]);
          if (pos < bs * cnt) begin
            idx = pos / bs;
            if (idx < cnt && busy[idx]) begin
              busy[idx] = 1'b0;
              if (tally < bs) tally = '0;
              else tally = TALLY_W'(tally - bs);
              rep.ok = 1'b1;
            end
          end
        end
        if (rep.ok) n_freed++;
        else n_ignored++;
      end
      rep.bytes = tally;
      pending_replies.push_back(rep);
    endfunction

    function void check_reply(logic ok, logic [OUT_OFF_W-1:0] blk_off,
                              logic [TALLY_W-1:0] bytes);
      alloc_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: ok %0d offset %0d bytes %0d",
               ok, blk_off, bytes);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      n_checked++;
      if (ok !== want.ok) begin
        $error("ok: expected %0d, actual %0d", want.ok, ok);
        errors++;
      end
      if (blk_off !== want.blk_off) begin
        $error("block_offset: expected %0d, actual %0d", want.blk_off, blk_off);
        errors++;
      end
      if (bytes !== want.bytes) begin
        $error("bytes_in_use: expected %0d, actual %0d", want.bytes, bytes);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction
  endclass

  // Every input has a known value from time zero.
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_opcode = OP_ALLOC;
  logic signed [IN_OFF_W-1:0] in_byte_offset = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_ok;
  logic [OUT_OFF_W-1:0]       out_block_offset;
  logic [TALLY_W-1:0]         out_bytes_in_use;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_BLOCK_BYTES;
  logic [CFG_W-1:0]           cfg_wdata = '0;

  alloc_scoreboard sb = new();

  // Idle controls shared between the request side and the reply side.
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_req   = 1'b0;
  int hold_count = 0;

  fixed_block_pool_allocator_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_byte_offset   (in_byte_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_block_offset (out_block_offset),
    .out_bytes_in_use (out_bytes_in_use),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reply monitor. Sampling right at the edge sees the values that were
  // settled before it, so the handshake reads the same as the block sees it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_reply(out_ok, out_block_offset, out_bytes_in_use);
  end

  // Reply side backpressure. A hold request pins out_stall high for a long
  // stretch so the result register fills, the block takes one more request
  // and then has to stall its input. Otherwise, with idling on, short random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        hold_count++;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: reset or any cycle with a transaction on either channel restarts it.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("no transaction for %0d cycles, %0d replies outstanding",
             STUCK_LIMIT, sb.outstanding());
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Valid stays high
  // into the next request unless a random gap follows, so it is never lowered
  // and raised within one step.
  task automatic send_req(op_t op, logic signed [IN_OFF_W-1:0] off);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_byte_offset <= off;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_request(op, off);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every reply; the block is idle afterwards.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  // Block count lives in the low byte; the upper write data bits get junk.
  task automatic set_pool(logic [BB_W-1:0] bytes, logic [BC_W-1:0] count);
    wait_idle();
    write_reg(REG_BLOCK_BYTES, bytes);
    write_reg(REG_BLOCK_COUNT, {(CFG_W - BC_W)'($urandom()), count});
  endtask

  // Random request. Most frees name a byte somewhere inside a busy block so
  // they actually release something; the rest are noise: whole-range junk,
  // negative offsets, offsets at or past the pool end, or possibly free blocks.
  task automatic random_req(int alloc_pct);
    int unsigned bs, cnt;
    int blk;
    op_t op;
    logic signed [IN_OFF_W-1:0] off;
    bs  = sb.blk_size();
    cnt = sb.pool_blocks();
    off = IN_OFF_W'($urandom());
    if ($urandom_range(0, 99) < alloc_pct) begin
      op = OP_ALLOC;
    end else begin
      op = OP_FREE;
      if ($urandom_range(0, 9) < 8) begin
        blk = sb.pick_busy();
        if (blk >= 0) off = IN_OFF_W'(blk * bs + $urandom_range(0, bs - 1));
        else if (cnt > 0) off = IN_OFF_W'($urandom_range(0, bs * cnt - 1));
      end else begin
        case ($urandom_range(0, 3))
          0: ;
          1: off = IN_OFF_W'(-$signed($urandom_range(1, OFFSET_SPAN)));
          2: off = IN_OFF_W'(bs * cnt + $urandom_range(0, 2 * ALIGN));
          default: if (cnt > 0) off = IN_OFF_W'($urandom_range(0, bs * cnt - 1));
        endcase
      end
    end
    send_req(op, off);
  endtask

  initial begin
    logic [BB_W-1:0] bytes;
    logic [BC_W-1:0] count;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset geometry: 32-byte blocks, 100 of them.
    send_req(OP_FREE, 0);                    // free of a block never taken
    send_req(OP_ALLOC, 0);                   // block 0
    send_req(OP_ALLOC, 0);                   // block 1
    send_req(OP_ALLOC, 0);                   // block 2
    send_req(OP_FREE, 33);                   // byte inside block 1
    send_req(OP_FREE, 33);                   // same block again: already free
    send_req(OP_ALLOC, -1);                  // lowest free is block 1 again
    send_req(OP_FREE, -1);                   // negative offsets
    send_req(OP_FREE, -OFFSET_SPAN);
    send_req(OP_FREE, OFFSET_SPAN - 1);      // largest positive offset
    send_req(OP_FREE, 3200);                 // exactly the pool end
    send_req(OP_FREE, 3199);                 // last byte, block not busy
    send_req(OP_ALLOC, 0);                   // block 3
    send_req(OP_FREE, 95);                   // last byte of block 2

    // Shrink to two blocks: both busy, so the pool is full, and block 3
    // stays busy but out of reach.
    set_pool(13'd32, 8'd2);
    send_req(OP_ALLOC, 0);
    send_req(OP_FREE, 96);
    send_req(OP_FREE, 63);
    send_req(OP_ALLOC, 0);

    // Empty pool: nothing can be taken or released.
    set_pool(13'd32, 8'd0);
    send_req(OP_ALLOC, 0);
    send_req(OP_FREE, 0);

    // Random phases. The first few sit on the register extremes (size 0 and
    // 1 round to 8, sizes past 4096 clamp, counts past 128 clamp, count 0);
    // the rest are random, mostly small pools so full and empty both happen.
    // Blocks left busy from one phase carry into the next under a new size,
    // which also drives the tally into its floor.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin bytes = 13'd0;    count = 8'd3;   end
        1: begin bytes = 13'd8191; count = 8'd255; end
        2: begin bytes = 13'd4096; count = 8'd128; end
        3: begin bytes = 13'd1;    count = 8'd0;   end
        4: begin bytes = 13'd4097; count = 8'd1;   end
        default: begin
          bytes = ($urandom_range(0, 3) == 0) ? BB_W'($urandom())
                                              : BB_W'($urandom_range(1, 200));
          count = ($urandom_range(0, 4) == 0) ? BC_W'($urandom())
                                              : BC_W'($urandom_range(1, 24));
        end
      endcase
      set_pool(bytes, count);

      // The last stretch runs with no idling on either side; phase 2 keeps
      // the sender busy while the receiver holds off.
      tx_idle_on = (p < NUM_PHASES - 2) && (p != 2) && ($urandom_range(0, 2) != 0);
      rx_idle_on = (p < NUM_PHASES - 2) && ($urandom_range(0, 2) != 0);
      if (p == 2) hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++)
        random_req((p % 2 == 0) ? 65 : 35);
    end

    wait_idle();
    repeat (20) @(posedge clk);

    $display("%0d requests over %0d register writes: %0d allocs granted, %0d refused",
             sb.n_requests, sb.n_settings, sb.n_granted, sb.n_refused);
    $display("%0d frees taken, %0d ignored; %0d replies checked, %0d long output holds",
             sb.n_freed, sb.n_ignored, sb.n_checked, hold_count);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/fbpa_pkg.sv
hdl/fbpa_cell.sv
hdl/fbpa_div.sv
hdl/fixed_block_pool_allocator_top.sv
hdl/fbpa_chk.sv
verif/fixed_block_pool_allocator_top_test.sv
